[hdl/disk_pair_overlap_resolver_top_defines.svh]
// Assertion macros shared by the resolver RTL.
`ifndef DISK_PAIR_OVERLAP_RESOLVER_TOP_DEFINES_SVH
`define DISK_PAIR_OVERLAP_RESOLVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DPOR_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dpor check failed");
`define DPOR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpor check failed");
`else
`define DPOR_ASSERT(lbl, clk, rst_n, cond)
`define DPOR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/dpor_pkg.sv]
`default_nettype none
package dpor_pkg;

    localparam int SqrtStages = 18;
    localparam int DivStages  = 18;

    localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] POS_MIN = 24'sh800000;

    // per-pair data carried alongside the arithmetic
    typedef struct packed {
        logic signed [23:0] x1;
        logic signed [23:0] y1;
        logic signed [23:0] x2;
        logic signed [23:0] y2;
        logic [16:0]        rsum;
        logic [16:0]        adx;
        logic [16:0]        ady;
        logic               dxneg;
        logic               dyneg;
        logic               fix1;
        logic               fix2;
        logic               ok;
    } side_t;

endpackage
`default_nettype wire

[hdl/dpor_front.sv]
`default_nettype none
module dpor_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  first_x,
    input  logic signed [23:0]  first_y,
    input  logic [15:0]         first_radius,
    input  logic                first_fixed,
    input  logic                first_virtual,
    input  logic signed [23:0]  second_x,
    input  logic signed [23:0]  second_y,
    input  logic [15:0]         second_radius,
    input  logic                second_fixed,
    input  logic                second_virtual,
    output logic                out_valid,
    input  logic                out_stall,
    output dpor_pkg::side_t     out_side,
    output logic [35:0]         out_sumsq
);
    import dpor_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic signed [23:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [16:0]        rsum_reg;
    logic               fix1_reg, fix2_reg, vir_reg;
    logic signed [24:0] dx_reg, dy_reg;

    side_t              side2_reg, side2_next;
    side_t              side3_reg;
    logic [33:0]        sqx_reg, sqy_reg;
    side_t              side4_reg;
    logic [35:0]        sum_reg;

    logic [24:0]        adx_w, ady_w;

    assign en4 = !v4_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    assign adx_w = dx_reg[24] ? 25'(-dx_reg) : 25'(dx_reg);
    assign ady_w = dy_reg[24] ? 25'(-dy_reg) : 25'(dy_reg);

    always_comb
    begin
        side2_next.x1    = x1_reg;
        side2_next.y1    = y1_reg;
        side2_next.x2    = x2_reg;
        side2_next.y2    = y2_reg;
        side2_next.rsum  = rsum_reg;
        side2_next.adx   = adx_w[16:0];
        side2_next.ady   = ady_w[16:0];
        side2_next.dxneg = dx_reg[24];
        side2_next.dyneg = dy_reg[24];
        side2_next.fix1  = fix1_reg;
        side2_next.fix2  = fix2_reg;
        // far pairs can never overlap: radii sum stays below 2^17
        side2_next.ok    = !vir_reg && (dx_reg != '0 || dy_reg != '0)
                           && (adx_w[24:17] == '0) && (ady_w[24:17] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg   <= first_x;
            y1_reg   <= first_y;
            x2_reg   <= second_x;
            y2_reg   <= second_y;
            rsum_reg <= {1'b0, first_radius} + {1'b0, second_radius};
            fix1_reg <= first_fixed;
            fix2_reg <= second_fixed;
            vir_reg  <= first_virtual || second_virtual;
            dx_reg   <= {second_x[23], second_x} - {first_x[23], first_x};
            dy_reg   <= {second_y[23], second_y} - {first_y[23], first_y};
        end
        if (en2)
            side2_reg <= side2_next;
        if (en3)
        begin
            side3_reg <= side2_reg;
            sqx_reg   <= 34'(side2_reg.adx) * 34'(side2_reg.adx);
            sqy_reg   <= 34'(side2_reg.ady) * 34'(side2_reg.ady);
        end
        if (en4)
        begin
            side4_reg <= side3_reg;
            sum_reg   <= {2'b00, sqx_reg} + {2'b00, sqy_reg};
        end
    end

    assign out_valid = v4_reg;
    assign out_side  = side4_reg;
    assign out_sumsq = sum_reg;

endmodule
`default_nettype wire

[hdl/dpor_sqrt.sv]
`default_nettype none
`include "disk_pair_overlap_resolver_top_defines.svh"
module dpor_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  dpor_pkg::side_t  in_side,
    input  logic [35:0]      in_sumsq,
    output logic             out_valid,
    input  logic             out_stall,
    output dpor_pkg::side_t  out_side,
    output logic [17:0]      root
);
    import dpor_pkg::*;

    localparam int NS = SqrtStages;

    logic        v_reg    [NS];
    logic        en       [NS];
    logic        pv_w     [NS];
    logic [20:0] rem_reg  [NS];
    logic [20:0] rem_next [NS];
    logic [17:0] root_reg [NS];
    logic [17:0] root_next[NS];
    logic [35:0] val_reg  [NS];
    logic [35:0] val_w    [NS];
    side_t       side_reg [NS];
    side_t       side_w   [NS];

    // one root bit per stage, restoring
    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int Bit = NS - 1 - k;
        logic [20:0] pr;
        logic [20:0] sh;
        logic [20:0] trial;
        logic [17:0] ro;
        logic        ge;
        if (k == 0)
        begin : g_first
            assign pr        = '0;
            assign ro        = '0;
            assign pv_w[k]   = in_valid;
            assign val_w[k]  = in_sumsq;
            assign side_w[k] = in_side;
        end
        else
        begin : g_next
            assign pr        = rem_reg[k-1];
            assign ro        = root_reg[k-1];
            assign pv_w[k]   = v_reg[k-1];
            assign val_w[k]  = val_reg[k-1];
            assign side_w[k] = side_reg[k-1];
        end
        if (k == NS - 1)
        begin : g_last_en
            assign en[k] = !v_reg[k] || !out_stall;
        end
        else
        begin : g_mid_en
            assign en[k] = !v_reg[k] || en[k+1];
        end
        assign sh           = {pr[18:0], val_w[k][2*Bit+1 -: 2]};
        assign trial        = {1'b0, ro, 2'b01};
        assign ge           = sh >= trial;
        assign rem_next[k]  = ge ? sh - trial : sh;
        assign root_next[k] = {ro[16:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
                if (en[k]) v_reg[k] <= pv_w[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                val_reg[k]  <= val_w[k];
                side_reg[k] <= side_w[k];
            end
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign root      = root_reg[NS-1];

    logic [36:0] r_chk;
    logic [36:0] sq_lo;
    logic [36:0] sq_hi;
    assign r_chk = {19'd0, root_reg[NS-1]};
    assign sq_lo = r_chk * r_chk;
    assign sq_hi = (r_chk + 37'd1) * (r_chk + 37'd1);

    `DPOR_ASSERT_IMPL(a_root_not_high, clk, rst_n, out_valid, sq_lo <= {1'b0, val_reg[NS-1]})
    `DPOR_ASSERT_IMPL(a_root_not_low, clk, rst_n, out_valid, sq_hi > {1'b0, val_reg[NS-1]})

endmodule
`default_nettype wire

[hdl/dpor_scale.sv]
`default_nettype none
module dpor_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  dpor_pkg::side_t  in_side,
    input  logic [17:0]      in_dist,
    output logic             out_valid,
    input  logic             out_stall,
    output dpor_pkg::side_t  out_side,
    output logic [35:0]      nx,
    output logic [35:0]      ny,
    output logic [18:0]      den
);
    import dpor_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    side_t       side1_reg, side1_next;
    logic [16:0] ad_reg;
    logic [17:0] dist1_reg;
    logic [18:0] gap_w;

    side_t       side2_reg;
    logic [33:0] px_reg, py_reg;
    logic [17:0] dist2_reg;

    side_t       side3_reg;
    logic [35:0] nx_reg, ny_reg;
    logic [18:0] den_reg;

    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    // overlap depth: radii sum minus distance
    assign gap_w = {2'b00, in_side.rsum} - {1'b0, in_dist};

    always_comb
    begin
        side1_next    = in_side;
        side1_next.ok = in_side.ok && !gap_w[18];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            side1_reg <= side1_next;
            ad_reg    <= side1_next.ok ? gap_w[16:0] : '0;
            dist1_reg <= in_dist;
        end
        if (en2)
        begin
            side2_reg <= side1_reg;
            px_reg    <= 34'(ad_reg) * 34'(side1_reg.adx);
            py_reg    <= 34'(ad_reg) * 34'(side1_reg.ady);
            dist2_reg <= dist1_reg;
        end
        if (en3)
        begin
            side3_reg <= side2_reg;
            if (side2_reg.fix1 || side2_reg.fix2)
            begin
                nx_reg <= {1'b0, px_reg, 1'b0} + {18'd0, dist2_reg};
                ny_reg <= {1'b0, py_reg, 1'b0} + {18'd0, dist2_reg};
            end
            else
            begin
                nx_reg <= {2'b00, px_reg} + {18'd0, dist2_reg};
                ny_reg <= {2'b00, py_reg} + {18'd0, dist2_reg};
            end
            den_reg <= {dist2_reg, 1'b0};
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign nx        = nx_reg;
    assign ny        = ny_reg;
    assign den       = den_reg;

endmodule
`default_nettype wire

[hdl/dpor_div.sv]
`default_nettype none
`include "disk_pair_overlap_resolver_top_defines.svh"
module dpor_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  dpor_pkg::side_t  in_side,
    input  logic [35:0]      in_nx,
    input  logic [35:0]      in_ny,
    input  logic [18:0]      in_den,
    output logic             out_valid,
    input  logic             out_stall,
    output dpor_pkg::side_t  out_side,
    output logic [17:0]      qx,
    output logic [17:0]      qy
);
    import dpor_pkg::*;

    localparam int NS = DivStages;

    logic        v_reg    [NS];
    logic        en       [NS];
    logic        pv_w     [NS];
    logic [19:0] rx_reg   [NS];
    logic [19:0] rx_next  [NS];
    logic [19:0] ry_reg   [NS];
    logic [19:0] ry_next  [NS];
    logic [17:0] qx_reg   [NS];
    logic [17:0] qx_next  [NS];
    logic [17:0] qy_reg   [NS];
    logic [17:0] qy_next  [NS];
    logic [35:0] nx_reg   [NS];
    logic [35:0] nx_w     [NS];
    logic [35:0] ny_reg   [NS];
    logic [35:0] ny_w     [NS];
    logic [18:0] d_reg    [NS];
    logic [18:0] d_w      [NS];
    side_t       side_reg [NS];
    side_t       side_w   [NS];

    // both axes share one restoring divider pipeline, one quotient bit per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int Bit = NS - 1 - k;
        logic [19:0] prx, pry, shx, shy, dd;
        logic [17:0] pqx, pqy;
        logic        gex, gey;
        if (k == 0)
        begin : g_first
            assign prx       = {2'b00, in_nx[35:18]};
            assign pry       = {2'b00, in_ny[35:18]};
            assign pqx       = '0;
            assign pqy       = '0;
            assign pv_w[k]   = in_valid;
            assign nx_w[k]   = in_nx;
            assign ny_w[k]   = in_ny;
            assign d_w[k]    = in_den;
            assign side_w[k] = in_side;
        end
        else
        begin : g_next
            assign prx       = rx_reg[k-1];
            assign pry       = ry_reg[k-1];
            assign pqx       = qx_reg[k-1];
            assign pqy       = qy_reg[k-1];
            assign pv_w[k]   = v_reg[k-1];
            assign nx_w[k]   = nx_reg[k-1];
            assign ny_w[k]   = ny_reg[k-1];
            assign d_w[k]    = d_reg[k-1];
            assign side_w[k] = side_reg[k-1];
        end
        if (k == NS - 1)
        begin : g_last_en
            assign en[k] = !v_reg[k] || !out_stall;
        end
        else
        begin : g_mid_en
            assign en[k] = !v_reg[k] || en[k+1];
        end
        assign dd         = {1'b0, d_w[k]};
        assign shx        = {prx[18:0], nx_w[k][Bit]};
        assign shy        = {pry[18:0], ny_w[k][Bit]};
        assign gex        = shx >= dd;
        assign gey        = shy >= dd;
        assign rx_next[k] = gex ? shx - dd : shx;
        assign ry_next[k] = gey ? shy - dd : shy;
        assign qx_next[k] = {pqx[16:0], gex};
        assign qy_next[k] = {pqy[16:0], gey};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
                if (en[k]) v_reg[k] <= pv_w[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                rx_reg[k]   <= rx_next[k];
                ry_reg[k]   <= ry_next[k];
                qx_reg[k]   <= qx_next[k];
                qy_reg[k]   <= qy_next[k];
                nx_reg[k]   <= nx_w[k];
                ny_reg[k]   <= ny_w[k];
                d_reg[k]    <= d_w[k];
                side_reg[k] <= side_w[k];
            end
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign qx        = qx_reg[NS-1];
    assign qy        = qy_reg[NS-1];

    logic [36:0] prod_x, prod_y, num_x, num_y, den_c;
    logic        chk_en;
    assign den_c  = {18'd0, d_reg[NS-1]};
    assign num_x  = {1'b0, nx_reg[NS-1]};
    assign num_y  = {1'b0, ny_reg[NS-1]};
    assign prod_x = {19'd0, qx_reg[NS-1]} * den_c;
    assign prod_y = {19'd0, qy_reg[NS-1]} * den_c;
    assign chk_en = v_reg[NS-1] && side_reg[NS-1].ok;

    `DPOR_ASSERT_IMPL(a_quot_x, clk, rst_n, chk_en, prod_x <= num_x && num_x - prod_x < den_c)
    `DPOR_ASSERT_IMPL(a_quot_y, clk, rst_n, chk_en, prod_y <= num_y && num_y - prod_y < den_c)

endmodule
`default_nettype wire

[hdl/disk_pair_overlap_resolver_top.sv]
// channel   handshake                 payload
// input     in_valid / in_stall       first_*, second_* (x, y, radius, fixed, virtual)
// output    out_valid / out_stall     new_first_x/y, new_second_x/y, was_resolved
//
// One word per cycle in and out while out_stall stays low. Registers: 4 front,
// 18 square root, 3 scale, 18 divide, 1 output register. The bit-serial root and
// divider pipelines set the depth. rst_n clears every valid bit; data registers hold.
// Stalls back-pressure stage by stage, so bubbles are squeezed out and the
// input keeps taking words while the output word waits, until every stage is full.
`default_nettype none
`include "disk_pair_overlap_resolver_top_defines.svh"
module disk_pair_overlap_resolver_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  first_x,
    input  logic signed [23:0]  first_y,
    input  logic [15:0]         first_radius,
    input  logic                first_fixed,
    input  logic                first_virtual,
    input  logic signed [23:0]  second_x,
    input  logic signed [23:0]  second_y,
    input  logic [15:0]         second_radius,
    input  logic                second_fixed,
    input  logic                second_virtual,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [23:0]  new_first_x,
    output logic signed [23:0]  new_first_y,
    output logic signed [23:0]  new_second_x,
    output logic signed [23:0]  new_second_y,
    output logic                was_resolved
);
    import dpor_pkg::*;

    logic        f_valid, f_stall;
    side_t       f_side;
    logic [35:0] f_sumsq;

    logic        s_valid, s_stall;
    side_t       s_side;
    logic [17:0] s_dist;

    logic        c_valid, c_stall;
    side_t       c_side;
    logic [35:0] c_nx, c_ny;
    logic [18:0] c_den;

    logic        d_valid, d_stall;
    side_t       d_side;
    logic [17:0] d_qx, d_qy;

    dpor_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_x        (first_x),
        .first_y        (first_y),
        .first_radius   (first_radius),
        .first_fixed    (first_fixed),
        .first_virtual  (first_virtual),
        .second_x       (second_x),
        .second_y       (second_y),
        .second_radius  (second_radius),
        .second_fixed   (second_fixed),
        .second_virtual (second_virtual),
        .out_valid      (f_valid),
        .out_stall      (f_stall),
        .out_side       (f_side),
        .out_sumsq      (f_sumsq)
    );

    dpor_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_stall  (f_stall),
        .in_side   (f_side),
        .in_sumsq  (f_sumsq),
        .out_valid (s_valid),
        .out_stall (s_stall),
        .out_side  (s_side),
        .root      (s_dist)
    );

    dpor_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_stall  (s_stall),
        .in_side   (s_side),
        .in_dist   (s_dist),
        .out_valid (c_valid),
        .out_stall (c_stall),
        .out_side  (c_side),
        .nx        (c_nx),
        .ny        (c_ny),
        .den       (c_den)
    );

    dpor_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_stall  (c_stall),
        .in_side   (c_side),
        .in_nx     (c_nx),
        .in_ny     (c_ny),
        .in_den    (c_den),
        .out_valid (d_valid),
        .out_stall (d_stall),
        .out_side  (d_side),
        .qx        (d_qx),
        .qy        (d_qy)
    );

    logic               o_valid_reg;
    logic               o_en;
    logic signed [23:0] nx1_reg, ny1_reg, nx2_reg, ny2_reg;
    logic               res_reg;

    logic signed [19:0] mvx, mvy, m1x, m1y, m2x, m2y;
    logic signed [25:0] sx1, sy1, sx2, sy2;
    logic               take1, take2;

    function automatic logic signed [23:0] sat26(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v[25:23] == 3'b000 || v[25:23] == 3'b111)
            r = v[23:0];
        else if (v[25])
            r = POS_MIN;
        else
            r = POS_MAX;
        return r;
    endfunction

    assign o_en    = !o_valid_reg || !out_stall;
    assign d_stall = !o_en;

    // push is against the offset direction
    assign mvx   = d_side.dxneg ? $signed({2'b00, d_qx}) : -$signed({2'b00, d_qx});
    assign mvy   = d_side.dyneg ? $signed({2'b00, d_qy}) : -$signed({2'b00, d_qy});
    assign take1 = d_side.ok && !d_side.fix1;
    assign take2 = d_side.ok && !(!d_side.fix1 && d_side.fix2);
    assign m1x   = take1 ? mvx : '0;
    assign m1y   = take1 ? mvy : '0;
    assign m2x   = take2 ? mvx : '0;
    assign m2y   = take2 ? mvy : '0;

    assign sx1 = {{2{d_side.x1[23]}}, d_side.x1} + {{6{m1x[19]}}, m1x};
    assign sy1 = {{2{d_side.y1[23]}}, d_side.y1} + {{6{m1y[19]}}, m1y};
    assign sx2 = {{2{d_side.x2[23]}}, d_side.x2} - {{6{m2x[19]}}, m2x};
    assign sy2 = {{2{d_side.y2[23]}}, d_side.y2} - {{6{m2y[19]}}, m2y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_en)
            o_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (o_en)
        begin
            nx1_reg <= sat26(sx1);
            ny1_reg <= sat26(sy1);
            nx2_reg <= sat26(sx2);
            ny2_reg <= sat26(sy2);
            res_reg <= d_side.ok;
        end
    end

    assign out_valid    = o_valid_reg;
    assign new_first_x  = nx1_reg;
    assign new_first_y  = ny1_reg;
    assign new_second_x = nx2_reg;
    assign new_second_y = ny2_reg;
    assign was_resolved = res_reg;

    `DPOR_ASSERT_IMPL(a_empty_takes_input, clk, rst_n, !o_valid_reg, !in_stall)

endmodule
`default_nettype wire
